// ----- rtl/tchs_pkg.sv -----
// Shared types, constants and helpers for the three-channel histogram smoother.
// No dependencies; used by every module in rtl/ except tchs_ram.
package tchs_pkg;

  localparam int NUM_CH     = 3;
  localparam int MAX_BINS   = 1024;
  localparam int ADDR_W     = $clog2(MAX_BINS);
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 37;
  localparam int MAX_RADIUS = 15;
  localparam int WIN_LEN    = 2 * MAX_RADIUS + 1;
  localparam int WIN_W      = 5;
  localparam int NB_W       = 11;
  localparam int DIV_STEPS  = SUM_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] ONE_COUNT = CNT_W'(256);
  localparam logic [CNT_W-1:0] SAT_LEVEL = COUNT_MAX - ONE_COUNT;

  localparam logic [2:0] KIND_ACC    = 3'd0;
  localparam logic [2:0] KIND_READ   = 3'd1;
  localparam logic [2:0] KIND_WRITE  = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_SMOOTH = 3'd4;

  localparam logic [1:0] CH_INVALID = 2'd3;

  localparam logic REG_MIN_VALUE = 1'b0;
  localparam logic REG_NUM_BINS  = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RW,
    ST_RESP,
    ST_SM_CHECK,
    ST_LOAD_RD,
    ST_LOAD_CAP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SM_WR,
    ST_NEXT_RD,
    ST_NEXT_CAP
  } state_t;

  typedef struct packed {
    logic latch;
    logic clr_start;
    logic clr_step;
    logic acc_rd;
    logic acc_wr;
    logic rw_access;
    logic resp;
    logic sm_init;
    logic load_rd;
    logic load_cap;
    logic div_start;
    logic sm_wr;
    logic next_rd;
    logic next_cap;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       clr_last;
    logic       load_last;
    logic       has_next;
    logic       sm_skip;
    logic       div_done;
  } stat_t;

  function automatic logic in_range(input logic [15:0] v, input logic [15:0] m,
                                    input logic [NB_W-1:0] used);
    logic [16:0] d;
    d = {v[15], v} - {m[15], m};
    return !d[16] && (d[15:0] < {5'd0, used});
  endfunction

  function automatic logic [ADDR_W-1:0] bin_idx(input logic [15:0] v, input logic [15:0] m);
    logic [15:0] d;
    d = v - m;
    return d[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/tchs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tchs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tchs_div.sv -----
// Restoring divider, one quotient bit per cycle: window sum / window length.
// Depends on tchs_pkg.
module tchs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [tchs_pkg::SUM_W-1:0]   dividend,
  input  logic [tchs_pkg::WIN_W-1:0]   divisor,
  output logic [tchs_pkg::CNT_W-1:0]   quotient,
  output logic                         done
);

  logic [tchs_pkg::SUM_W-1:0] q;
  logic [tchs_pkg::WIN_W-1:0] rem;
  logic [5:0]                 steps;
  logic [tchs_pkg::WIN_W:0]   trial;
  logic                       qbit;

  assign trial = {rem, q[tchs_pkg::SUM_W-1]};
  assign qbit  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (go) begin
      steps <= 6'(tchs_pkg::DIV_STEPS);
    end else if (steps != '0) begin
      steps <= steps - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q   <= dividend;
      rem <= '0;
    end else if (steps != '0) begin
      q   <= {q[tchs_pkg::SUM_W-2:0], qbit};
      rem <= qbit ? tchs_pkg::WIN_W'(trial - {1'b0, divisor}) : trial[tchs_pkg::WIN_W-1:0];
    end
  end

  assign quotient = q[tchs_pkg::CNT_W-1:0];
  assign done     = steps == '0;

endmodule

// ----- rtl/tchs_ctrl.sv -----
// Controller state machine: sequences item handling, clear sweeps and smoothing.
// Depends on tchs_pkg; drives the datapath through cmd_t, watches stat_t.
module tchs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tchs_pkg::stat_t  stat,
  output tchs_pkg::cmd_t   cmd,
  output logic             busy
);

  tchs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tchs_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tchs_pkg::ST_INIT:     if (stat.clr_last) state_next = tchs_pkg::ST_IDLE;
      tchs_pkg::ST_IDLE: begin
        if (start) begin
          priority case (stat.kind)
            tchs_pkg::KIND_ACC:    state_next = tchs_pkg::ST_ACC_RD;
            tchs_pkg::KIND_READ,
            tchs_pkg::KIND_WRITE:  state_next = tchs_pkg::ST_RW;
            tchs_pkg::KIND_CLEAR:  state_next = tchs_pkg::ST_CLEAR;
            tchs_pkg::KIND_SMOOTH: state_next = tchs_pkg::ST_SM_CHECK;
            default:               state_next = tchs_pkg::ST_RESP;
          endcase
        end
      end
      tchs_pkg::ST_CLEAR:    if (stat.clr_last) state_next = tchs_pkg::ST_RESP;
      tchs_pkg::ST_ACC_RD:   state_next = tchs_pkg::ST_ACC_WR;
      tchs_pkg::ST_ACC_WR:   state_next = tchs_pkg::ST_RESP;
      tchs_pkg::ST_RW:       state_next = tchs_pkg::ST_RESP;
      tchs_pkg::ST_RESP:     state_next = tchs_pkg::ST_IDLE;
      tchs_pkg::ST_SM_CHECK: state_next = stat.sm_skip ? tchs_pkg::ST_RESP : tchs_pkg::ST_LOAD_RD;
      tchs_pkg::ST_LOAD_RD:  state_next = tchs_pkg::ST_LOAD_CAP;
      tchs_pkg::ST_LOAD_CAP: state_next = stat.load_last ? tchs_pkg::ST_DIV_GO
                                                         : tchs_pkg::ST_LOAD_RD;
      tchs_pkg::ST_DIV_GO:   state_next = tchs_pkg::ST_DIV_WAIT;
      tchs_pkg::ST_DIV_WAIT: if (stat.div_done) state_next = tchs_pkg::ST_SM_WR;
      tchs_pkg::ST_SM_WR:    state_next = stat.has_next ? tchs_pkg::ST_NEXT_RD
                                                        : tchs_pkg::ST_RESP;
      tchs_pkg::ST_NEXT_RD:  state_next = tchs_pkg::ST_NEXT_CAP;
      tchs_pkg::ST_NEXT_CAP: state_next = tchs_pkg::ST_DIV_GO;
      default:               state_next = tchs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = state != tchs_pkg::ST_IDLE;
    unique case (state)
      tchs_pkg::ST_INIT:     cmd.clr_step  = 1'b1;
      tchs_pkg::ST_IDLE: begin
        cmd.latch     = start;
        cmd.clr_start = start;
      end
      tchs_pkg::ST_CLEAR:    cmd.clr_step  = 1'b1;
      tchs_pkg::ST_ACC_RD:   cmd.acc_rd    = 1'b1;
      tchs_pkg::ST_ACC_WR:   cmd.acc_wr    = 1'b1;
      tchs_pkg::ST_RW:       cmd.rw_access = 1'b1;
      tchs_pkg::ST_RESP:     cmd.resp      = 1'b1;
      tchs_pkg::ST_SM_CHECK: cmd.sm_init   = 1'b1;
      tchs_pkg::ST_LOAD_RD:  cmd.load_rd   = 1'b1;
      tchs_pkg::ST_LOAD_CAP: cmd.load_cap  = 1'b1;
      tchs_pkg::ST_DIV_GO:   cmd.div_start = 1'b1;
      tchs_pkg::ST_DIV_WAIT: cmd = '0;
      tchs_pkg::ST_SM_WR:    cmd.sm_wr     = 1'b1;
      tchs_pkg::ST_NEXT_RD:  cmd.next_rd   = 1'b1;
      tchs_pkg::ST_NEXT_CAP: cmd.next_cap  = 1'b1;
      default:               cmd = '0;
    endcase
  end

endmodule

// ----- rtl/tchs_dp.sv -----
// Datapath: item registers, three bin RAMs, window sums and shift lines, dividers.
// Depends on tchs_pkg, tchs_ram, tchs_div.
module tchs_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  tchs_pkg::cmd_t               cmd,
  output tchs_pkg::stat_t              stat,
  input  logic [15:0]                  min_value,
  input  logic [tchs_pkg::NB_W-1:0]    num_bins,
  input  logic [2:0]                   kind,
  input  logic [15:0]                  pixel_ch0,
  input  logic [15:0]                  pixel_ch1,
  input  logic [15:0]                  pixel_ch2,
  input  logic [1:0]                   channel_select,
  input  logic [15:0]                  bin_value,
  input  logic [31:0]                  write_data,
  input  logic [3:0]                   smooth_radius,
  output logic                         done,
  output logic [31:0]                  read_data,
  output logic [2:0]                   range_error,
  output logic                         saturated
);

  localparam int AW = tchs_pkg::ADDR_W;
  localparam int CW = tchs_pkg::CNT_W;

  // latched item
  logic [2:0]  kind_q;
  logic [15:0] pix_q [tchs_pkg::NUM_CH];
  logic [1:0]  ch_q;
  logic [15:0] bval_q;
  logic [31:0] wdata_q;
  logic [3:0]  rad_q;

  logic [tchs_pkg::NB_W-1:0] used;
  logic [tchs_pkg::WIN_W-1:0] win;
  logic [AW-1:0] cnt;
  logic [AW-1:0] b;
  logic [2:0]    err_acc;
  logic [2:0]    err_rw;
  logic          rw_ok;
  logic          sat_q;
  logic [AW-1:0] acc_idx [tchs_pkg::NUM_CH];
  logic [AW-1:0] rw_idx;

  logic          we    [tchs_pkg::NUM_CH];
  logic [AW-1:0] waddr [tchs_pkg::NUM_CH];
  logic [CW-1:0] wdat  [tchs_pkg::NUM_CH];
  logic [AW-1:0] raddr [tchs_pkg::NUM_CH];
  logic [CW-1:0] rdata [tchs_pkg::NUM_CH];
  logic [CW-1:0] quot  [tchs_pkg::NUM_CH];
  logic          ddone [tchs_pkg::NUM_CH];
  logic [tchs_pkg::SUM_W-1:0] wsum [tchs_pkg::NUM_CH];
  logic [CW-1:0] shline [tchs_pkg::NUM_CH][tchs_pkg::WIN_LEN];
  logic [2:0]    sat_hit;

  assign used = (num_bins > tchs_pkg::NB_W'(tchs_pkg::MAX_BINS))
                ? tchs_pkg::NB_W'(tchs_pkg::MAX_BINS) : num_bins;
  assign win  = {rad_q, 1'b1};

  always_comb begin
    for (int c = 0; c < tchs_pkg::NUM_CH; c++) begin
      err_acc[c] = !tchs_pkg::in_range(pix_q[c], min_value, used);
      acc_idx[c] = tchs_pkg::bin_idx(pix_q[c], min_value);
    end
  end

  assign rw_idx = tchs_pkg::bin_idx(bval_q, min_value);
  always_comb begin
    err_rw = '0;
    rw_ok  = 1'b0;
    if (ch_q == tchs_pkg::CH_INVALID) begin
      err_rw = 3'b111;
    end else if (!tchs_pkg::in_range(bval_q, min_value, used)) begin
      err_rw = 3'(1) << ch_q;
    end else begin
      rw_ok = 1'b1;
    end
  end

  assign stat.kind      = kind;
  assign stat.clr_last  = cnt == AW'(tchs_pkg::MAX_BINS - 1);
  assign stat.load_last = {{(AW-tchs_pkg::WIN_W){1'b0}}, cnt[tchs_pkg::WIN_W-1:0]} ==
                          AW'(win - 5'd1) && cnt[AW-1:tchs_pkg::WIN_W] == '0;
  assign stat.has_next  = ({1'b0, b} + tchs_pkg::NB_W'(rad_q) + tchs_pkg::NB_W'(1)) < used;
  assign stat.sm_skip   = rad_q == '0 || used < tchs_pkg::NB_W'(win);
  assign stat.div_done  = ddone[0] && ddone[1] && ddone[2];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q   <= kind;
      pix_q[0] <= pixel_ch0;
      pix_q[1] <= pixel_ch1;
      pix_q[2] <= pixel_ch2;
      ch_q     <= channel_select;
      bval_q   <= bin_value;
      wdata_q  <= write_data;
      rad_q    <= smooth_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr_start || cmd.sm_init) begin
      cnt <= '0;
    end else if (cmd.clr_step || cmd.load_cap) begin
      cnt <= cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sm_init) begin
      b <= AW'(rad_q);
    end else if (cmd.next_cap) begin
      b <= b + AW'(1);
    end
  end

  always_comb begin
    for (int c = 0; c < tchs_pkg::NUM_CH; c++) begin
      sat_hit[c] = !err_acc[c] && rdata[c] >= tchs_pkg::SAT_LEVEL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sat_q <= 1'b0;
    end else if (cmd.acc_wr) begin
      sat_q <= |sat_hit;
    end
  end

  // memory port steering
  always_comb begin
    for (int c = 0; c < tchs_pkg::NUM_CH; c++) begin
      we[c]    = 1'b0;
      waddr[c] = cnt;
      wdat[c]  = '0;
      raddr[c] = cnt;
      if (cmd.clr_step) begin
        we[c] = 1'b1;
      end else if (cmd.acc_rd) begin
        raddr[c] = acc_idx[c];
      end else if (cmd.acc_wr) begin
        we[c]    = !err_acc[c];
        waddr[c] = acc_idx[c];
        wdat[c]  = sat_hit[c] ? tchs_pkg::COUNT_MAX : rdata[c] + tchs_pkg::ONE_COUNT;
      end else if (cmd.rw_access) begin
        raddr[c] = rw_idx;
        waddr[c] = rw_idx;
        wdat[c]  = wdata_q;
        we[c]    = rw_ok && kind_q == tchs_pkg::KIND_WRITE && ch_q == 2'(c);
      end else if (cmd.load_rd) begin
        raddr[c] = cnt;
      end else if (cmd.sm_wr) begin
        we[c]    = 1'b1;
        waddr[c] = b;
        wdat[c]  = quot[c];
      end else if (cmd.next_rd) begin
        raddr[c] = b + AW'(rad_q) + AW'(1);
      end
    end
  end

  for (genvar g = 0; g < tchs_pkg::NUM_CH; g++) begin : g_ch
    tchs_ram #(.WIDTH(CW), .DEPTH(tchs_pkg::MAX_BINS)) u_ram (
      .clk   (clk),
      .we    (we[g]),
      .waddr (waddr[g]),
      .wdata (wdat[g]),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );

    tchs_div u_div (
      .clk      (clk),
      .rst      (rst),
      .go       (cmd.div_start),
      .dividend (wsum[g]),
      .divisor  (win),
      .quotient (quot[g]),
      .done     (ddone[g])
    );

    // shift line holds the original bins of the window, oldest at tap win-1
    always_ff @(posedge clk) begin
      if (cmd.sm_init) begin
        wsum[g] <= '0;
      end else if (cmd.load_cap) begin
        wsum[g] <= wsum[g] + tchs_pkg::SUM_W'(rdata[g]);
      end else if (cmd.next_cap) begin
        wsum[g] <= wsum[g] - tchs_pkg::SUM_W'(shline[g][win - 5'd1])
                   + tchs_pkg::SUM_W'(rdata[g]);
      end
      if (cmd.load_cap || cmd.next_cap) begin
        shline[g][0] <= rdata[g];
        for (int i = 1; i < tchs_pkg::WIN_LEN; i++) begin
          shline[g][i] <= shline[g][i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      read_data   <= '0;
      range_error <= '0;
      saturated   <= 1'b0;
      if (kind_q == tchs_pkg::KIND_ACC) begin
        range_error <= err_acc;
        saturated   <= sat_q;
      end else if (kind_q == tchs_pkg::KIND_READ || kind_q == tchs_pkg::KIND_WRITE) begin
        range_error <= err_rw;
        if (kind_q == tchs_pkg::KIND_READ && rw_ok) begin
          read_data <= rdata[ch_q];
        end
      end
    end
  end

endmodule

// ----- rtl/three_channel_histogram_smoother_unit.sv -----
// Top level of the three-channel histogram smoother: config registers and APB port.
// Depends on tchs_pkg, tchs_ctrl, tchs_dp.
//
// Three 1024-bin histograms of 24.8 counts. An item is taken when start is high and busy
// low; its one result word appears for a single cycle with done high and cannot be held
// off. After reset the block runs a clearing pass over every bin with busy high. Accumulate
// goes through a RAM read, a saturating add and write back, and the result; read and write
// through the RAM access and the result; clear one RAM row a cycle. Smoothing walks all
// three channels together: it reads bins one by one to fill the 2r+1 window, then per
// interior bin runs the one-bit-a-step divider (37 steps), the window read and write back.
module three_channel_histogram_smoother_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [15:0] pixel_ch0,
  input  logic [15:0] pixel_ch1,
  input  logic [15:0] pixel_ch2,
  input  logic [1:0]  channel_select,
  input  logic [15:0] bin_value,
  input  logic [31:0] write_data,
  input  logic [3:0]  smooth_radius,
  output logic        done,
  output logic [31:0] read_data,
  output logic [2:0]  range_error,
  output logic        saturated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]                 min_value;
  logic [tchs_pkg::NB_W-1:0]   num_bins;
  logic                        wr_en;
  tchs_pkg::cmd_t              cmd;
  tchs_pkg::stat_t             stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value <= '0;
      num_bins  <= tchs_pkg::NB_W'(256);
    end else if (wr_en) begin
      if (paddr[2] == tchs_pkg::REG_MIN_VALUE) begin
        min_value <= pwdata[15:0];
      end else begin
        num_bins <= pwdata[tchs_pkg::NB_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == tchs_pkg::REG_NUM_BINS) begin
      prdata = {{(32-tchs_pkg::NB_W){1'b0}}, num_bins};
    end else begin
      prdata = {{16{min_value[15]}}, min_value};
    end
  end

  tchs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tchs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .min_value      (min_value),
    .num_bins       (num_bins),
    .kind           (kind),
    .pixel_ch0      (pixel_ch0),
    .pixel_ch1      (pixel_ch1),
    .pixel_ch2      (pixel_ch2),
    .channel_select (channel_select),
    .bin_value      (bin_value),
    .write_data     (write_data),
    .smooth_radius  (smooth_radius),
    .done           (done),
    .read_data      (read_data),
    .range_error    (range_error),
    .saturated      (saturated)
  );

endmodule

// ----- tb/testbench.sv -----
// Testbench for three_channel_histogram_smoother_unit: drives random and directed
// commands, predicts every result word in a scoreboard class and compares them.
// Depends on tchs_pkg and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import tchs_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] px0;
    logic [15:0] px1;
    logic [15:0] px2;
    logic [1:0]  chan;
    logic [15:0] bval;
    logic [31:0] wdata;
    logic [3:0]  radius;
  } hist_cmd_t;

  typedef struct {
    logic [31:0] rd;
    logic [2:0]  err;
    logic        sat;
  } hist_resp_t;

  localparam logic [2:0] ADDR_MIN_VALUE = 3'd0;
  localparam logic [2:0] ADDR_NUM_BINS  = 3'd4;

  class hist_scoreboard;
    logic [CNT_W-1:0] counts[NUM_CH][MAX_BINS];
    logic signed [15:0] lo_value;
    logic [NB_W-1:0]  bin_total;
    hist_resp_t       pending[$];
    int               errors;

    function void reset_state();
      foreach (counts[c, b]) counts[c][b] = '0;
      lo_value  = '0;
      bin_total = NB_W'(256);
      errors    = 0;
    endfunction

    function int unsigned used_bins();
      return (bin_total > MAX_BINS) ? MAX_BINS : bin_total;
    endfunction

    function bit locate(input logic [15:0] v, output int unsigned idx);
      int d;
      d = int'($signed(v)) - int'(lo_value);
      idx = d;
      return d >= 0 && d < int'(used_bins());
    endfunction

    function void smooth_all(input int unsigned r);
      logic [CNT_W-1:0] orig[MAX_BINS];
      logic [SUM_W-1:0] acc;
      int unsigned n, w;
      n = used_bins();
      w = 2 * r + 1;
      if (r == 0 || n < w) return;
      for (int c = 0; c < NUM_CH; c++) begin
        orig = counts[c];
        for (int unsigned b = r; b + r < n; b++) begin
          acc = '0;
          for (int unsigned k = b - r; k <= b + r; k++) acc += orig[k];
          counts[c][b] = CNT_W'(acc / w);
        end
      end
    endfunction

    // Applies one accepted command and queues the word it should produce.
    function void note_cmd(input hist_cmd_t cmd);
      hist_resp_t e;
      int unsigned idx;
      logic [15:0] px[NUM_CH];
      e = '{rd: '0, err: '0, sat: 1'b0};
      px[0] = cmd.px0; px[1] = cmd.px1; px[2] = cmd.px2;
      case (cmd.kind)
        KIND_ACC: begin
          for (int c = 0; c < NUM_CH; c++) begin
            if (!locate(px[c], idx)) begin
              e.err[c] = 1'b1;
            end else if (counts[c][idx] >= SAT_LEVEL) begin
              counts[c][idx] = COUNT_MAX;
              e.sat = 1'b1;
            end else begin
              counts[c][idx] += ONE_COUNT;
            end
          end
        end
        KIND_READ, KIND_WRITE: begin
          if (cmd.chan == CH_INVALID) begin
            e.err = 3'b111;
          end else if (!locate(cmd.bval, idx)) begin
            e.err[cmd.chan] = 1'b1;
          end else if (cmd.kind == KIND_READ) begin
            e.rd = counts[cmd.chan][idx];
          end else begin
            counts[cmd.chan][idx] = cmd.wdata;
          end
        end
        KIND_CLEAR: foreach (counts[c, b]) counts[c][b] = '0;
        KIND_SMOOTH: smooth_all((cmd.radius > MAX_RADIUS) ? MAX_RADIUS : cmd.radius);
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void report(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_word(input hist_resp_t got);
      hist_resp_t e;
      if (pending.size() == 0) begin
        report("result word with none expected");
        return;
      end
      e = pending.pop_front();
      if (got.rd !== e.rd)
        report($sformatf("read_data %h, expected %h", got.rd, e.rd));
      if (got.err !== e.err)
        report($sformatf("range_error %b, expected %b", got.err, e.err));
      if (got.sat !== e.sat)
        report($sformatf("saturated %b, expected %b", got.sat, e.sat));
    endfunction
  endclass

  logic        clk, rst, start, busy, done, saturated;
  logic [2:0]  kind, range_error;
  logic [15:0] pixel_ch0, pixel_ch1, pixel_ch2, bin_value;
  logic [1:0]  channel_select;
  logic [31:0] write_data, read_data, pwdata, prdata;
  logic [3:0]  smooth_radius;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;

  hist_scoreboard sb;
  int accepted_cnt;
  int burst_left;
  bit bursty;

  three_channel_histogram_smoother_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result words are checked before the newly accepted command is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_word('{rd: read_data, err: range_error, sat: saturated});
      if (start && !busy) begin
        sb.note_cmd('{kind: kind, px0: pixel_ch0, px1: pixel_ch1, px2: pixel_ch2,
                      chan: channel_select, bval: bin_value, wdata: write_data,
                      radius: smooth_radius});
        accepted_cnt++;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_cmd(input hist_cmd_t cmd);
    int seen;
    if (bursty && burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    seen           = accepted_cnt;
    kind           = cmd.kind;
    pixel_ch0      = cmd.px0;
    pixel_ch1      = cmd.px1;
    pixel_ch2      = cmd.px2;
    channel_select = cmd.chan;
    bin_value      = cmd.bval;
    write_data     = cmd.wdata;
    smooth_radius  = cmd.radius;
    start          = 1'b1;
    do @(negedge clk); while (accepted_cnt == seen);
  endtask

  task automatic drain();
    start = 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (!pready);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_MIN_VALUE) sb.lo_value = data[15:0];
    else sb.bin_total = data[NB_W-1:0];
  endtask

  task automatic set_config(input logic [15:0] lo, input logic [NB_W-1:0] nb);
    drain();
    apb_write(ADDR_MIN_VALUE, {16'h0, lo});
    apb_write(ADDR_NUM_BINS, {21'h0, nb});
  endtask

  function automatic hist_cmd_t mk(input logic [2:0] k, input logic [15:0] a,
                                   input logic [1:0] ch, input logic [31:0] wd,
                                   input logic [3:0] r);
    return '{kind: k, px0: a, px1: a + 16'd1, px2: a - 16'd1, chan: ch, bval: a,
             wdata: wd, radius: r};
  endfunction

  // Pixel value mostly around the bins in use, sometimes anywhere.
  function automatic logic [15:0] pick_value();
    if ($urandom_range(0, 9) < 8)
      return 16'(int'(sb.lo_value) + int'($urandom_range(0, sb.used_bins() + 1)) - 1);
    return 16'($urandom);
  endfunction

  function automatic hist_cmd_t random_cmd();
    hist_cmd_t cmd;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    cmd.px0    = pick_value();
    cmd.px1    = pick_value();
    cmd.px2    = pick_value();
    cmd.chan   = ($urandom_range(0, 19) == 0) ? CH_INVALID : 2'($urandom_range(0, 2));
    cmd.bval   = pick_value();
    cmd.wdata  = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FE00 + $urandom_range(0, 511)
                                             : $urandom;
    cmd.radius = 4'($urandom);
    if (sel < 45) cmd.kind = KIND_ACC;
    else if (sel < 65) cmd.kind = KIND_READ;
    else if (sel < 85) cmd.kind = KIND_WRITE;
    else if (sel < 88) cmd.kind = KIND_CLEAR;
    else if (sel < 95) cmd.kind = (sb.used_bins() > 64 && sel != 94) ? KIND_READ : KIND_SMOOTH;
    else cmd.kind = 3'($urandom_range(5, 7));
    return cmd;
  endfunction

  initial begin
    logic [15:0] lo;
    logic [NB_W-1:0] nb;
    int n_items;
    sb = new();
    sb.reset_state();
    accepted_cnt = 0;
    burst_left = 0;
    bursty = 1'b0;
    rst = 1'b1; start = 1'b0; kind = '0;
    pixel_ch0 = '0; pixel_ch1 = '0; pixel_ch2 = '0; channel_select = '0;
    bin_value = '0; write_data = '0; smooth_radius = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: default config, 256 bins from zero
    send_cmd(mk(KIND_ACC, 16'd0, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_ACC, 16'h8000, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_ACC, 16'h7FFF, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_ACC, 16'd255, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_READ, 16'd0, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_READ, 16'd1, 2'd1, 32'd0, 4'd0));
    send_cmd(mk(KIND_WRITE, 16'd10, 2'd0, 32'hFFFF_FFFF, 4'd0));
    send_cmd(mk(KIND_ACC, 16'd10, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_WRITE, 16'd20, 2'd2, 32'hFFFF_FEFF, 4'd0));
    send_cmd(mk(KIND_ACC, 16'd21, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_READ, 16'd20, 2'd2, 32'd0, 4'd0));
    send_cmd(mk(KIND_READ, 16'd5, CH_INVALID, 32'd0, 4'd0));
    send_cmd(mk(KIND_WRITE, 16'd300, 2'd1, 32'h1234_5678, 4'd0));
    send_cmd(mk(KIND_READ, 16'hFFFF, 2'd1, 32'd0, 4'd0));
    send_cmd(mk(KIND_SMOOTH, 16'd0, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_SMOOTH, 16'd0, 2'd0, 32'd0, 4'd15));
    send_cmd(mk(KIND_READ, 16'd10, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(3'd5, 16'd0, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(3'd6, 16'd0, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(3'd7, 16'd0, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_CLEAR, 16'd0, 2'd0, 32'd0, 4'd0));
    send_cmd(mk(KIND_READ, 16'd10, 2'd0, 32'd0, 4'd0));

    // configs: zero bins, window wider than the bins, more bins than exist, extremes
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin lo = 16'h8000; nb = NB_W'(0); end
        1: begin lo = 16'h7FFF; nb = NB_W'(1); end
        2: begin lo = 16'hFFF0; nb = NB_W'(20); end
        3: begin lo = 16'h8000; nb = NB_W'(2047); end
        4: begin lo = 16'h7FF0; nb = NB_W'(1024); end
        default: begin lo = 16'($urandom); nb = NB_W'($urandom_range(2, 48)); end
      endcase
      set_config(lo, nb);
      bursty = ph[0];
      n_items = (ph == 3 || ph == 4) ? 40 : 280;
      repeat (n_items) send_cmd(random_cmd());
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
